>>> sv/sitrd_pkg.sv
// Shared types and constants for the signed integer to radix text converter.
`timescale 1ns / 1ps
`default_nettype none

package sitrd_pkg;

   // Character sent ahead of the digits of a negative number.
   localparam logic [7:0] MINUS_CHAR = 8'h2D;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_OUTPUT
   } state_type;

   // Per-cycle command broadcast to every digit cell.
   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> sv/signed_int_to_radix_digits.sv
// Top level of the signed integer to radix text converter.
//
//   channel   direction  ports                                   accepted when
//   request   in         start, busy, req_value                  start && !busy
//   response  out        rsp_valid, rsp_text_char, rsp_last_char rsp_valid (one cycle)
//   config    in         csr_wr_en, csr_index, csr_wr_data       csr_wr_en
//
// A request keeps busy high through ST_CONVERT and ST_OUTPUT: in ST_CONVERT the magnitude
// is fed one bit a cycle into the row of digit cells, then in ST_OUTPUT the digits shift up
// and out, leading zeros dropped, one character a cycle. Characters appear from output
// registers in the cycle after they are chosen, the minus sign while the magnitude is still
// being fed in and the final character in the cycle busy falls, when the next request can
// be taken. Reset restores radix 10 and zero symbols; no output stall.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_radix_digits #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_RADIX  = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  signed [VALUE_BITS-1:0]          req_value,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_text_char,
   output logic                                  rsp_last_char,
   input  wire                                   csr_wr_en,
   input  wire  [sitrd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [63:0]                           csr_wr_data
);

   localparam int DIGIT_BITS = $clog2(MAX_RADIX);
   localparam int RADIX_BITS = DIGIT_BITS + 1;
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam int EXT_BITS   = (DIGIT_BITS > 4) ? DIGIT_BITS : 4;

   // Configuration registers.
   logic [4:0]  radix_ff;
   logic [63:0] symbols_low_ff;
   logic [63:0] symbols_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= 5'd10;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sitrd_pkg::CSR_RADIX:        radix_ff        <= csr_wr_data[4:0];
            sitrd_pkg::CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_wr_data;
            sitrd_pkg::CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Radix clamped into the supported range.
   logic [RADIX_BITS-1:0] eff_radix;

   always_comb begin
      if (radix_ff < 5'd2) begin
         eff_radix = RADIX_BITS'(2);
      end else if (32'(radix_ff) > MAX_RADIX) begin
         eff_radix = RADIX_BITS'(MAX_RADIX);
      end else begin
         eff_radix = RADIX_BITS'(radix_ff);
      end
   end

   // Controller and datapath registers.
   sitrd_pkg::state_type  state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  started_ff, started_in;
   logic                  neg_ff;
   logic [VALUE_BITS-1:0] mag_ff;
   logic [RADIX_BITS-1:0] work_radix_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_text_char_ff, rsp_text_char_in;
   logic                  rsp_last_char_ff, rsp_last_char_in;

   logic                     accept;
   logic                     req_neg;
   logic [VALUE_BITS-1:0]    req_mag;
   sitrd_pkg::cell_ctl_type  cell_ctl;
   logic [DIGIT_BITS-1:0]    top_digit;
   logic                     overflow;
   logic [EXT_BITS-1:0]      top_ext;
   logic [7:0]               top_symbol;
   logic                     emit_digit;

   assign accept  = start && !busy;
   assign req_neg = req_value[VALUE_BITS-1];
   assign req_mag = req_neg ? (~$unsigned(req_value) + VALUE_BITS'(1)) : $unsigned(req_value);

   // Symbol lookup for the digit in the top cell; digits past the table give zero.
   always_comb begin
      top_ext = EXT_BITS'(top_digit);
      if ((top_ext >> 4) != '0) begin
         top_symbol = 8'h00;
      end else if (top_ext[3]) begin
         top_symbol = symbols_high_ff[{top_ext[2:0], 3'b000} +: 8];
      end else begin
         top_symbol = symbols_low_ff[{top_ext[2:0], 3'b000} +: 8];
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitrd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state, cell commands and the next character.
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      started_in       = started_ff;
      cell_ctl         = '0;
      rsp_valid_in     = 1'b0;
      rsp_text_char_in = top_symbol;
      rsp_last_char_in = 1'b0;
      emit_digit       = 1'b0;
      busy             = (state_ff != sitrd_pkg::ST_IDLE);

      unique case (state_ff)
         sitrd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in       = sitrd_pkg::ST_CONVERT;
               cnt_in         = CNT_BITS'(VALUE_BITS);
               started_in     = 1'b0;
               cell_ctl.clear = 1'b1;
            end
         end
         sitrd_pkg::ST_CONVERT: begin
            cell_ctl.convert = 1'b1;
            // The sign goes out while the first magnitude bit enters the row.
            if (neg_ff && (cnt_ff == CNT_BITS'(VALUE_BITS))) begin
               rsp_valid_in     = 1'b1;
               rsp_text_char_in = sitrd_pkg::MINUS_CHAR;
            end
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = sitrd_pkg::ST_OUTPUT;
               cnt_in   = CNT_BITS'(VALUE_BITS);
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         sitrd_pkg::ST_OUTPUT: begin
            cell_ctl.shift = 1'b1;
            // Leading zeros are dropped, but the lowest digit always goes out.
            emit_digit = started_ff || (top_digit != '0) || (cnt_ff == CNT_BITS'(1));
            if (emit_digit) begin
               rsp_valid_in     = 1'b1;
               rsp_last_char_in = (cnt_ff == CNT_BITS'(1));
               started_in       = 1'b1;
            end
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = sitrd_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         default: begin
            state_in = sitrd_pkg::ST_IDLE;
         end
      endcase
   end

   // Working registers for the request in progress.
   always_ff @(posedge clock) begin
      cnt_ff           <= cnt_in;
      started_ff       <= started_in;
      rsp_text_char_ff <= rsp_text_char_in;
      rsp_last_char_ff <= rsp_last_char_in;
      if (accept) begin
         neg_ff        <= req_neg;
         mag_ff        <= req_mag;
         work_radix_ff <= eff_radix;
      end else if (cell_ctl.convert) begin
         mag_ff <= {mag_ff[VALUE_BITS-2:0], 1'b0};
      end
   end

   // Row of digit cells fed most significant bit first.
   sitrd_chain #(
      .CELLS      (VALUE_BITS),
      .DIGIT_BITS (DIGIT_BITS)
   ) u_chain (
      .clock     (clock),
      .ctl       (cell_ctl),
      .radix     (work_radix_ff),
      .bit_in    (mag_ff[VALUE_BITS-1]),
      .top_digit (top_digit),
      .overflow  (overflow)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_text_char_ff;
   assign rsp_last_char = rsp_last_char_ff;

   // An accepted request makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but block not busy");

   // Characters only follow a cycle in which a request was in progress.
   a_valid_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("character sent without a request in progress");

   // The final character leaves as the block becomes idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> !busy)
      else $error("final character sent while still busy");

   // The last output cycle always yields the final character.
   a_last_emitted: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sitrd_pkg::ST_OUTPUT) && (cnt_ff == CNT_BITS'(1)))
      |=> (rsp_valid && rsp_last_char))
      else $error("final character missing");

   // The row of cells is wide enough for any magnitude.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sitrd_pkg::ST_CONVERT) |-> !overflow)
      else $error("digit row overflowed");

endmodule

`default_nettype wire

>>> sv/sitrd_cell.sv
// One digit cell: doubles its digit and adds the carry, or takes its lower neighbor's digit.
`timescale 1ns / 1ps
`default_nettype none

module sitrd_cell #(
   parameter int DIGIT_BITS = 4
) (
   input  wire                           clock,
   input  wire sitrd_pkg::cell_ctl_type  ctl,
   input  wire  [DIGIT_BITS:0]           radix,
   input  wire                           carry_in,
   input  wire  [DIGIT_BITS-1:0]         lower_digit,
   output logic                          carry_out,
   output logic [DIGIT_BITS-1:0]         digit_out
);

   logic [DIGIT_BITS-1:0] digit_ff;
   logic [DIGIT_BITS-1:0] digit_in;
   logic [DIGIT_BITS:0]   doubled;
   logic [DIGIT_BITS:0]   reduced;
   logic                  carry_gen;
   logic                  carry_prop;

   // Digit times two plus carry stays below twice the radix, so one subtract reduces it.
   // Whether the doubled digit reaches the radix with a zero or a one shifted in depends
   // only on this cell, so the carry passes through a single AND-OR per cell.
   always_comb begin
      carry_gen  = ({digit_ff, 1'b0} >= radix);
      carry_prop = ({digit_ff, 1'b1} >= radix);
      carry_out  = carry_gen || (carry_prop && carry_in);
      doubled    = {digit_ff, carry_in};
      reduced    = doubled - radix;
   end

   // Clear on a new request, convert while bits shift in, shift up while digits go out.
   always_comb begin
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.convert) begin
         digit_in = carry_out ? reduced[DIGIT_BITS-1:0] : doubled[DIGIT_BITS-1:0];
      end else if (ctl.shift) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_out = digit_ff;

endmodule

`default_nettype wire

>>> sv/sitrd_chain.sv
// Row of digit cells that turns a bit stream into radix digits and shifts them out.
`timescale 1ns / 1ps
`default_nettype none

module sitrd_chain #(
   parameter int CELLS      = 32,
   parameter int DIGIT_BITS = 4
) (
   input  wire                           clock,
   input  wire sitrd_pkg::cell_ctl_type  ctl,
   input  wire  [DIGIT_BITS:0]           radix,
   input  wire                           bit_in,
   output logic [DIGIT_BITS-1:0]         top_digit,
   output logic                          overflow
);

   logic [CELLS:0]        carry;
   logic [DIGIT_BITS-1:0] digit [CELLS];

   assign carry[0] = bit_in;

   // Cell zero holds the least significant digit; carries and digits move upward.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic [DIGIT_BITS-1:0] lower_digit;

      if (i == 0) begin : g_bottom
         assign lower_digit = '0;
      end else begin : g_inner
         assign lower_digit = digit[i-1];
      end

      sitrd_cell #(
         .DIGIT_BITS (DIGIT_BITS)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .radix       (radix),
         .carry_in    (carry[i]),
         .lower_digit (lower_digit),
         .carry_out   (carry[i+1]),
         .digit_out   (digit[i])
      );
   end

   assign top_digit = digit[CELLS-1];
   assign overflow  = carry[CELLS];

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the signed integer to radix text converter.
`timescale 1ns / 1ps

module testbench;

   localparam int VALUE_BITS    = 32;
   localparam int MAX_RADIX     = 16;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_FROM    = 150;
   localparam int QUIET_TO      = 250;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 40;
   localparam int TIMEOUT_NS    = 1000000;

   // Index past the end of the register list; writes to it must be dropped.
   localparam logic [sitrd_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   // Symbol tables: ASCII digits with upper or lower case letters.
   localparam logic [63:0] ASCII_DIGITS_LOW  = 64'h3736353433323130;
   localparam logic [63:0] ASCII_UPPER_HIGH  = 64'h4645444342413938;
   localparam logic [63:0] ASCII_LOWER_HIGH  = 64'h6665646362613938;

   typedef enum logic [1:0] {
      JOB_CONVERT,
      JOB_WRITE,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type                          kind;
      logic [VALUE_BITS-1:0]                 value;
      logic [sitrd_pkg::CSR_INDEX_BITS-1:0]  index;
      logic [63:0]                           data;
   } job_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } text_out_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  start = 1'b0;
   logic [VALUE_BITS-1:0]                 req_value = '0;
   logic                                  csr_wr_en = 1'b0;
   logic [sitrd_pkg::CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [63:0]                           csr_wr_data = '0;
   logic                                  busy;
   logic                                  rsp_valid;
   logic [7:0]                            rsp_text_char;
   logic                                  rsp_last_char;

   job_type      queued_requests[$];
   text_out_type expected_chars[$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int           sent_count = 0;

   // Predictor's copy of the configuration registers.
   logic [4:0]   cfg_radix;
   logic [63:0]  cfg_symbols_low;
   logic [63:0]  cfg_symbols_high;

   signed_int_to_radix_digits #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_RADIX (MAX_RADIX)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_text_char(rsp_text_char),
      .rsp_last_char(rsp_last_char),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic add_conversion(input logic [VALUE_BITS-1:0] value);
      job_type job;
      job = '{kind: JOB_CONVERT, value: value, index: '0, data: '0};
      queued_requests.push_back(job);
   endtask

   task automatic add_register_write(input logic [sitrd_pkg::CSR_INDEX_BITS-1:0] index,
                                     input logic [63:0] data);
      job_type job;
      job = '{kind: JOB_WRITE, value: '0, index: index, data: data};
      queued_requests.push_back(job);
   endtask

   task automatic add_drain();
      job_type job;
      job = '{kind: JOB_DRAIN, value: '0, index: '0, data: '0};
      queued_requests.push_back(job);
   endtask

   // Works out the characters of one number under the current configuration.
   function automatic void predict_chars(input logic [VALUE_BITS-1:0] value);
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
      int unsigned           base;
      int unsigned           digit_values[0:VALUE_BITS];
      int                    count;
      int unsigned           digit;
      text_out_type          out_char;
      negative  = value[VALUE_BITS-1];
      magnitude = negative ? (~value + 1'b1) : value;
      base      = cfg_radix;
      if (base < 2) base = 2;
      if (base > MAX_RADIX) base = MAX_RADIX;
      count = 0;
      do begin
         digit_values[count] = magnitude % base;
         magnitude           = magnitude / base;
         count++;
      end while (magnitude != 0 && count < VALUE_BITS + 1);
      if (negative) begin
         out_char = '{text_char: sitrd_pkg::MINUS_CHAR, last_char: 1'b0};
         expected_chars.push_back(out_char);
      end
      for (int i = count - 1; i >= 0; i--) begin
         digit = digit_values[i];
         if (digit < 8) begin
            out_char.text_char = cfg_symbols_low[digit*8 +: 8];
         end else if (digit < 16) begin
            out_char.text_char = cfg_symbols_high[(digit-8)*8 +: 8];
         end else begin
            out_char.text_char = 8'h00;
         end
         out_char.last_char = (i == 0);
         expected_chars.push_back(out_char);
      end
   endfunction

   // Random values weighted toward small magnitudes and the extremes.
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] result;
      case ($urandom_range(0, 5))
         0, 1: begin
            result = $urandom;
         end
         2: begin
            result = $urandom >> $urandom_range(0, 31);
         end
         3: begin
            result = -($urandom >> $urandom_range(0, 31));
         end
         4: begin
            result = $urandom_range(0, 40) - 20;
         end
         default: begin
            case ($urandom_range(0, 5))
               0: result = 32'h00000000;
               1: result = 32'h00000001;
               2: result = 32'hFFFFFFFF;
               3: result = 32'h7FFFFFFF;
               4: result = 32'h80000000;
               default: result = 32'h80000001;
            endcase
         end
      endcase
      return result;
   endfunction

   // Request driver: offers queued conversions and performs register writes
   // only once the converter has gone quiet.
   always @(posedge clock) begin : driver_proc
      logic                                 next_start;
      logic [VALUE_BITS-1:0]                next_value;
      logic                                 next_wr_en;
      logic [sitrd_pkg::CSR_INDEX_BITS-1:0] next_index;
      logic [63:0]                          next_data;
      logic                                 take_gap;
      logic                                 settled;
      next_start = start;
      next_value = req_value;
      next_wr_en = 1'b0;
      next_index = csr_index;
      next_data  = csr_wr_data;
      if (reset) begin
         next_start = 1'b0;
      end else if (!start || !busy) begin
         // Either nothing was offered or the offered request was taken here.
         if (start) sent_count++;
         next_start = 1'b0;
         settled    = !start && quiet_cycles >= SETTLE_CYCLES;
         take_gap   = !(sent_count >= QUIET_FROM && sent_count < QUIET_TO) &&
                      ($urandom_range(0, 99) < 20);
         if (!take_gap && queued_requests.size() != 0) begin
            case (queued_requests[0].kind)
               JOB_CONVERT: begin
                  next_start = 1'b1;
                  next_value = queued_requests[0].value;
                  void'(queued_requests.pop_front());
               end
               JOB_WRITE: begin
                  if (settled) begin
                     next_wr_en = 1'b1;
                     next_index = queued_requests[0].index;
                     next_data  = queued_requests[0].data;
                     void'(queued_requests.pop_front());
                  end
               end
               default: begin
                  if (settled) void'(queued_requests.pop_front());
               end
            endcase
         end
      end
      start       <= next_start;
      req_value   <= next_value;
      csr_wr_en   <= next_wr_en;
      csr_index   <= next_index;
      csr_wr_data <= next_data;
   end

   // Monitor: tracks register writes, predicts each accepted request and
   // checks every output character against the oldest expectation.
   always @(posedge clock) begin : monitor_proc
      text_out_type want;
      if (reset) begin
         cfg_radix        <= 5'd10;
         cfg_symbols_low  <= '0;
         cfg_symbols_high <= '0;
         quiet_cycles     <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("character %h with nothing expected",
                                         rsp_text_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_text_char !== want.text_char)
                  report_mismatch($sformatf("text_char %h, expected %h",
                                            rsp_text_char, want.text_char));
               if (rsp_last_char !== want.last_char)
                  report_mismatch($sformatf("last_char %b, expected %b",
                                            rsp_last_char, want.last_char));
            end
         end
         if (start && !busy) predict_chars(req_value);
         if (csr_wr_en) begin
            case (csr_index)
               sitrd_pkg::CSR_RADIX:        cfg_radix        <= csr_wr_data[4:0];
               sitrd_pkg::CSR_SYMBOLS_LOW:  cfg_symbols_low  <= csr_wr_data;
               sitrd_pkg::CSR_SYMBOLS_HIGH: cfg_symbols_high <= csr_wr_data;
               default: ;
            endcase
         end
         if (expected_chars.size() == 0 && !busy && !start)
            quiet_cycles <= quiet_cycles + 1;
         else
            quiet_cycles <= 0;
      end
   end

   // Stimulus and end of run.
   initial begin : sequence_proc
      logic [63:0] data;
      // Reset configuration: radix 10 and symbols still all zero.
      add_conversion(32'd0);
      add_conversion(32'hFFFFFFFF);
      add_conversion(32'd12345);

      // Decimal with real symbols, both extremes of the value.
      add_register_write(sitrd_pkg::CSR_SYMBOLS_LOW, ASCII_DIGITS_LOW);
      add_register_write(sitrd_pkg::CSR_SYMBOLS_HIGH, ASCII_UPPER_HIGH);
      add_conversion(32'h7FFFFFFF);
      add_conversion(32'h80000000);
      add_conversion(32'd0);
      add_conversion(-32'sd7);

      // Largest radix.
      add_register_write(sitrd_pkg::CSR_RADIX, 64'd16);
      add_conversion(32'h80000000);
      add_conversion(32'hFFFFFFFF);
      add_conversion(32'h7FFFFFFF);
      add_conversion(32'd15);

      // Binary: the most negative value gives the longest text.
      add_register_write(sitrd_pkg::CSR_RADIX, 64'd2);
      add_conversion(32'h80000000);
      add_conversion(32'h7FFFFFFF);
      add_conversion(32'd1);

      // Radix zero and one fall back to binary; upper data bits are dropped.
      add_register_write(sitrd_pkg::CSR_RADIX, 64'hFFFFFFFFFFFFFFE0);
      add_conversion(32'd5);
      add_conversion(-32'sd5);
      add_register_write(sitrd_pkg::CSR_RADIX, 64'h21);
      add_conversion(32'd3);

      // Radix above the maximum is clamped to sixteen.
      add_register_write(sitrd_pkg::CSR_RADIX, 64'h1F);
      add_conversion(32'h80000000);
      add_conversion(32'hDEADBEEF);
      add_register_write(sitrd_pkg::CSR_RADIX, 64'd17);
      add_conversion(32'd255);

      // A write past the register list must change nothing.
      add_register_write(CSR_UNUSED, 64'hFFFFFFFFFFFFFFFF);
      add_conversion(32'd1234);
      add_drain();

      // Random phases, each under a fresh configuration.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase % 3 == 0) add_drain();
         if ($urandom_range(0, 9) < 7) begin
            data = $urandom_range(2, MAX_RADIX);
         end else begin
            data = {$urandom, $urandom};
         end
         add_register_write(sitrd_pkg::CSR_RADIX, data);
         case ($urandom_range(0, 2))
            0: begin
               add_register_write(sitrd_pkg::CSR_SYMBOLS_LOW, ASCII_DIGITS_LOW);
               add_register_write(sitrd_pkg::CSR_SYMBOLS_HIGH, ASCII_UPPER_HIGH);
            end
            1: begin
               add_register_write(sitrd_pkg::CSR_SYMBOLS_LOW, ASCII_DIGITS_LOW);
               add_register_write(sitrd_pkg::CSR_SYMBOLS_HIGH, ASCII_LOWER_HIGH);
            end
            default: begin
               add_register_write(sitrd_pkg::CSR_SYMBOLS_LOW, {$urandom, $urandom});
               add_register_write(sitrd_pkg::CSR_SYMBOLS_HIGH, {$urandom, $urandom});
            end
         endcase
         if ($urandom_range(0, 3) == 0)
            add_register_write(CSR_UNUSED, {$urandom, $urandom});
         for (int i = 0; i < PHASE_ITEMS; i++) add_conversion(random_value());
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every character to arrive.
      do @(negedge clock);
      while (queued_requests.size() != 0 || start || expected_chars.size() != 0);
      repeat (2 * VALUE_BITS + 4) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hung converter.
   initial begin : timeout_proc
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule
